/* hw/rtl/safezone_stop_tracker_assert.svh */
// Assertion macros for the safezone stop tracker
`ifndef SAFEZONE_STOP_TRACKER_ASSERT_SVH
`define SAFEZONE_STOP_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SZ_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define SZ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define SZ_ASSERT_IMPL(label, clk, rst, prop)
`define SZ_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hw/rtl/szst_pkg.sv */
`timescale 1ns / 1ps
package szst_pkg;
   localparam int MAX_LOOKBACK_DEF = 64;
   localparam int MAX_HOLD_DEF = 32;
   localparam int PRICE_W = 24;
   localparam int STOP_W = 42;
   localparam int INDEX_W = 16;
   localparam int CFG_IDX_W = 2;
   localparam int CFG_DATA_W = 16;
   localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_COEF = 2'd3;
endpackage

/* hw/rtl/szst_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module szst_divider #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[NUM_W-1]} - {2'b0, d_ff};
      if (start) begin
         q_in = numer;
         r_in = '0;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next numerator bit, subtract if it fits
         if (!trial[DEN_W+1]) begin
            r_in = trial[DEN_W:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= denom;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

/* hw/rtl/safezone_stop_tracker.sv */
`timescale 1ns / 1ps
// Per bar: each window bar is read through one memory read port (read, wait,
// accumulate), then multiply, serial divide, and a read and compare per hold
// entry. Bars too early for a stop are stored but give no response.
// A new bar is taken only in idle, after the rsp beat of the last one.
// Reset: synchronous, active high; clears control, counters and registers to
// mode 0, lookback 10, hold 2, coef 512. Histories are not cleared.
module safezone_stop_tracker
   import szst_pkg::*;
#(
   parameter int MAX_LOOKBACK = MAX_LOOKBACK_DEF,
   parameter int MAX_HOLD = MAX_HOLD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [szst_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [szst_pkg::CFG_DATA_W-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [szst_pkg::PRICE_W-1:0]    req_bar_high,
   input  logic [szst_pkg::PRICE_W-1:0]    req_bar_low,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [szst_pkg::STOP_W-1:0] rsp_stop_level
);
   `include "safezone_stop_tracker_assert.svh"

   localparam int DEPTH = MAX_LOOKBACK + 1;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int LB_W = $clog2(MAX_LOOKBACK + 1);
   localparam int HOLD_W = $clog2(MAX_HOLD + 1);
   localparam int HP_W = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;
   localparam int SUM_W = PRICE_W + LB_W;
   localparam int NUM_W = SUM_W + 16;
   localparam int CNT_W = LB_W;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_RDW, S_ACC, S_MUL, S_DIV, S_DIVW, S_HRD, S_HCMP, S_OUT
   } state_type;

   state_type state_ff;
   logic       mode_ff;
   logic [6:0] lookback_ff;
   logic [5:0] hold_ff;
   logic [15:0] coef_ff;

   logic [2*PRICE_W-1:0] price_mem [DEPTH];
   logic [STOP_W-1:0]  stop_mem [MAX_HOLD];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2*PRICE_W-1:0] rd_word_ff;
   logic [PRICE_W-1:0] rd_price, cur_ff;
   logic [INDEX_W-1:0] bar_idx_ff, n_ff;
   logic [HOLD_W-1:0]  made_ff, hcnt_ff;
   logic [HP_W-1:0]    stop_head_ff, hptr_ff;
   logic [LB_W-1:0]    lb_ff, d_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   numer_ff;
   logic signed [STOP_W-1:0] raw_ff, adj_ff, srd_ff;
   logic               first_ff;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   quot;
   logic [LB_W-1:0]    lb_eff;
   logic [HOLD_W-1:0]  hold_eff;

   assign lb_eff = ({25'd0, lookback_ff} > 32'(MAX_LOOKBACK)) ? LB_W'(MAX_LOOKBACK)
                                                             : LB_W'(lookback_ff);
   assign hold_eff = ({26'd0, hold_ff} > 32'(MAX_HOLD)) ? HOLD_W'(MAX_HOLD)
                                                       : HOLD_W'(hold_ff);
   // both prices are kept so a mode change sees the full history
   assign rd_price = mode_ff ? rd_word_ff[2*PRICE_W-1:PRICE_W] : rd_word_ff[PRICE_W-1:0];

   // config beats win over a waiting bar
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign div_start = (state_ff == S_DIV);

   szst_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer_ff), .denom(cnt_ff), .done(div_done), .quot(quot)
   );

   function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] p);
      ptr_back = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic logic [HP_W-1:0] hold_back(input logic [HP_W-1:0] p);
      hold_back = (p == '0) ? HP_W'(MAX_HOLD - 1) : p - 1'b1;
   endfunction

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) price_mem[wr_ptr_ff] <= {req_bar_high, req_bar_low};
      rd_word_ff <= price_mem[rd_ptr_ff];
      if (state_ff == S_OUT && rsp_ready) stop_mem[stop_head_ff] <= raw_ff;
      srd_ff <= stop_mem[hptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 1'b0;
         lookback_ff <= 7'd10;
         hold_ff <= 6'd2;
         coef_ff <= 16'd512;
         wr_ptr_ff <= '0;
         bar_idx_ff <= '0;
         made_ff <= '0;
         stop_head_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     REG_MODE:     mode_ff <= csr_data[0];
                     REG_LOOKBACK: lookback_ff <= csr_data[6:0];
                     REG_HOLD:     hold_ff <= csr_data[5:0];
                     REG_COEF:     coef_ff <= csr_data;
                     default: ;
                  endcase
               end else if (req_valid) begin
                  n_ff <= bar_idx_ff;
                  if (bar_idx_ff != '1) bar_idx_ff <= bar_idx_ff + 1'b1;
                  wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  rd_ptr_ff <= wr_ptr_ff;
                  lb_ff <= lb_eff;
                  d_ff <= '0;
                  sum_ff <= '0;
                  cnt_ff <= '0;
                  first_ff <= 1'b1;
                  if (INDEX_W'(lb_eff) <= bar_idx_ff) state_ff <= S_RD;
               end
            end
            // one read issued per window bar, walking back through the window
            S_RD: state_ff <= S_RDW;
            S_RDW: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (first_ff) begin
                  cur_ff <= rd_price;
                  raw_ff <= $signed({{(STOP_W-PRICE_W-8){1'b0}}, rd_price, 8'b0});
                  first_ff <= 1'b0;
               end else begin
                  cur_ff <= rd_price;
                  // cur_ff holds bar j, rd_price bar j-1
                  if (!mode_ff && rd_price > cur_ff) begin
                     sum_ff <= sum_ff + SUM_W'(rd_price - cur_ff);
                     cnt_ff <= cnt_ff + 1'b1;
                  end else if (mode_ff && cur_ff > rd_price) begin
                     sum_ff <= sum_ff + SUM_W'(cur_ff - rd_price);
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  d_ff <= d_ff + 1'b1;
               end
               rd_ptr_ff <= ptr_back(rd_ptr_ff);
               if (!first_ff && (d_ff + 1'b1 >= lb_ff ||
                     INDEX_W'(d_ff) + INDEX_W'(3) > n_ff))
                  state_ff <= S_MUL;
               else if (first_ff && (lb_ff == '0 || n_ff < INDEX_W'(2)))
                  state_ff <= S_MUL;
               else
                  state_ff <= S_RD;
            end
            // product of the final sum, ready before the divider starts
            S_MUL: begin
               numer_ff <= NUM_W'(coef_ff) * NUM_W'(sum_ff);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               state_ff <= S_DIVW;
            end
            S_DIVW: if (div_done) begin
               if (cnt_ff != '0) begin
                  if (mode_ff)
                     raw_ff <= raw_ff + $signed({1'b0, quot[STOP_W-2:0]});
                  else
                     raw_ff <= raw_ff - $signed({1'b0, quot[STOP_W-2:0]});
               end
               hptr_ff <= hold_back(stop_head_ff);
               hcnt_ff <= '0;
               state_ff <= S_HRD;
            end
            S_HRD: begin
               if (hcnt_ff == '0) adj_ff <= raw_ff;
               if (hcnt_ff >= hold_eff || hcnt_ff >= made_ff) state_ff <= S_OUT;
               else state_ff <= S_HCMP;
            end
            S_HCMP: begin
               if (!mode_ff && srd_ff > adj_ff) adj_ff <= srd_ff;
               if (mode_ff && srd_ff < adj_ff) adj_ff <= srd_ff;
               hcnt_ff <= hcnt_ff + 1'b1;
               hptr_ff <= hold_back(hptr_ff);
               state_ff <= S_HRD;
            end
            S_OUT: if (rsp_ready) begin
               stop_head_ff <= (stop_head_ff == HP_W'(MAX_HOLD - 1)) ? '0
                                                                     : stop_head_ff + 1'b1;
               if (made_ff != HOLD_W'(MAX_HOLD)) made_ff <= made_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_stop_level = adj_ff;

   `SZ_ASSERT_IMPL(a_one_side, clock, reset, !(rsp_valid && req_ready))
   `SZ_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_stop_level))
   `SZ_ASSERT_NEXT(a_made_cap, clock, reset, 1'b1, made_ff <= HOLD_W'(MAX_HOLD))
endmodule
